>>> src/oiss_pkg.sv
// Package for the ordered integer set: command codes, transaction types and cell control.
`default_nettype none
package oiss_pkg;

	localparam int unsigned CAPACITY_DEF  = 256;
	localparam int unsigned VALUE_W       = 8;
	localparam int unsigned ENTRY_COUNT_W = 9;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_PEEK   = 2'd1,
		CMD_POP    = 2'd2,
		CMD_REMOVE = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                     success;
		logic [VALUE_W-1:0]       popped_value;
		logic                     overflow;
		logic [ENTRY_COUNT_W-1:0] entry_count;
	} res_t;

	typedef struct packed {
		logic               capture;
		logic               step;
		logic               add_wr;
		logic               rm_shift;
		logic [VALUE_W-1:0] value;
	} cell_ctl_t;

endpackage
`default_nettype wire

>>> src/ordered_int_set_stack.sv
// done rises at the commit edge, after the scan steps that follow the accepting edge,
// and the result is taken at the edge that follows.
// A new transaction is accepted only after the commit edge; the prefix scan across
// the cell row takes one doubling step per cycle, and busy stays high until the commit edge.
// Reset clears the entry count, the duplicate setting and the sequencer; cell contents are
// not cleared. The receiver cannot stall: done is high for exactly one cycle per transaction.
`default_nettype none
module ordered_int_set_stack
	import oiss_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t request,
	output logic      busy,
	output logic      done,
	output res_t      result,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata
);

	localparam int unsigned CW  = $clog2(CAPACITY + 1);
	localparam int unsigned LOG = $clog2(CAPACITY);

	cell_ctl_t          ctl;
	logic [CW-1:0]      count;
	logic [LOG-1:0]     step_oh;
	logic               hit_w   [CAPACITY];
	logic [VALUE_W-1:0] data_w  [CAPACITY];
	logic [VALUE_W-1:0] entry_w [CAPACITY];

	oiss_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.request  (request),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.any_hit  (hit_w[CAPACITY-1]),
		.pop_word (data_w[0]),
		.busy     (busy),
		.done     (done),
		.result   (result),
		.ctl      (ctl),
		.count    (count),
		.step_oh  (step_oh)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic               hc [LOG];
		logic [VALUE_W-1:0] dc [LOG];
		logic               far_hit;
		logic [VALUE_W-1:0] far_data;
		logic [VALUE_W-1:0] next_entry;

		for (genvar k = 0; k < LOG; k++) begin : g_tap
			if (i >= (1 << k)) begin : g_lo
				assign hc[k] = hit_w[i - (1 << k)];
			end else begin : g_lo_none
				assign hc[k] = 1'b0;
			end
			if (i + (1 << k) < CAPACITY) begin : g_hi
				assign dc[k] = data_w[i + (1 << k)];
			end else begin : g_hi_none
				assign dc[k] = '0;
			end
		end

		always_comb begin
			far_hit  = 1'b0;
			far_data = '0;
			for (int k = 0; k < LOG; k++) begin
				far_hit  = far_hit | (step_oh[k] & hc[k]);
				far_data = far_data | ({VALUE_W{step_oh[k]}} & dc[k]);
			end
		end

		if (i + 1 < CAPACITY) begin : g_next
			assign next_entry = entry_w[i + 1];
		end else begin : g_end
			assign next_entry = entry_w[i];
		end

		oiss_cell #(
			.CAPACITY(CAPACITY),
			.INDEX   (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.count     (count),
			.far_hit   (far_hit),
			.far_data  (far_data),
			.next_entry(next_entry),
			.entry     (entry_w[i]),
			.hit       (hit_w[i]),
			.data      (data_w[i])
		);
	end

endmodule
`default_nettype wire

>>> src/oiss_cell.sv
// One storage cell of the set: entry, prefix-match bit and pop-gather word.
`default_nettype none
module oiss_cell
	import oiss_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF,
	parameter int unsigned INDEX    = 0,
	localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
	input  wire logic               clk,
	input  wire cell_ctl_t          ctl,
	input  wire logic [CW-1:0]      count,
	input  wire logic               far_hit,
	input  wire logic [VALUE_W-1:0] far_data,
	input  wire logic [VALUE_W-1:0] next_entry,
	output logic [VALUE_W-1:0]      entry,
	output logic                    hit,
	output logic [VALUE_W-1:0]      data
);

	localparam logic [CW-1:0] IDX = CW'(INDEX);

	logic [VALUE_W-1:0] entry_q;
	logic               hit_q;
	logic [VALUE_W-1:0] data_q;
	logic               valid;
	logic               last;

	assign valid = IDX < count;
	assign last  = IDX == (count - CW'(1));

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			hit_q  <= valid && (entry_q == ctl.value);
			data_q <= last ? entry_q : '0;
		end else if (ctl.step) begin
			hit_q  <= hit_q | far_hit;
			data_q <= data_q | far_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.add_wr && (IDX == count)) begin
			entry_q <= ctl.value;
		end else if (ctl.rm_shift && hit_q) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;
	assign hit   = hit_q;
	assign data  = data_q;

endmodule
`default_nettype wire

>>> src/oiss_ctrl.sv
// Command sequencer: handshake, scan steps, entry count and result register.
`default_nettype none
module oiss_ctrl
	import oiss_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF,
	localparam int unsigned CW      = $clog2(CAPACITY + 1),
	localparam int unsigned LOG     = $clog2(CAPACITY)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire req_t               request,
	input  wire logic               cfg_we,
	input  wire logic               cfg_wdata,
	input  wire logic               any_hit,
	input  wire logic [VALUE_W-1:0] pop_word,
	output logic                    busy,
	output logic                    done,
	output res_t                    result,
	output cell_ctl_t               ctl,
	output logic [CW-1:0]           count,
	output logic [LOG-1:0]          step_oh
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_COMMIT = 3'b100
	} state_t;

	localparam logic [CW-1:0] CAP = CW'(CAPACITY);

	state_t             state_q;
	logic [LOG-1:0]     step_q;
	logic [CW-1:0]      count_q;
	logic               allow_q;
	cmd_t               cmd_q;
	logic [VALUE_W-1:0] value_q;
	logic               done_q;
	res_t               result_q;
	logic               accept;
	logic [CW-1:0]      count_d;
	res_t               res_d;
	logic               add_wr;
	logic               rm_shift;

	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		count_d  = count_q;
		add_wr   = 1'b0;
		rm_shift = 1'b0;
		res_d    = '0;
		unique case (cmd_q)
			CMD_ADD: begin
				if (!(!allow_q && any_hit)) begin
					if (count_q == CAP) begin
						res_d.overflow = 1'b1;
					end else begin
						add_wr        = 1'b1;
						count_d       = count_q + CW'(1);
						res_d.success = 1'b1;
					end
				end
			end
			CMD_PEEK: begin
				res_d.success = any_hit;
			end
			CMD_POP: begin
				if (count_q != '0) begin
					count_d            = count_q - CW'(1);
					res_d.popped_value = pop_word;
					res_d.success      = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (any_hit) begin
					rm_shift      = 1'b1;
					count_d       = count_q - CW'(1);
					res_d.success = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res_d.entry_count = ENTRY_COUNT_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			count_q <= '0;
			allow_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				allow_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						step_q  <= LOG'(1);
					end
				end
				ST_SCAN: begin
					if (step_q[LOG-1]) begin
						state_q <= ST_COMMIT;
					end
					step_q <= step_q << 1;
				end
				ST_COMMIT: begin
					count_q <= count_d;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= request.cmd;
			value_q <= request.value;
		end
		if (state_q == ST_COMMIT) begin
			result_q <= res_d;
		end
	end

	always_comb begin
		ctl.capture  = accept;
		ctl.step     = state_q == ST_SCAN;
		ctl.add_wr   = (state_q == ST_COMMIT) && add_wr;
		ctl.rm_shift = (state_q == ST_COMMIT) && rm_shift;
		ctl.value    = (state_q == ST_IDLE) ? request.value : value_q;
	end

	assign busy    = state_q != ST_IDLE;
	assign done    = done_q;
	assign result  = result_q;
	assign count   = count_q;
	assign step_oh = step_q;

endmodule
`default_nettype wire

>>> tb/tb_ordered_int_set_stack.sv
// Self-checking testbench for ordered_int_set_stack: directed corners, a fill to capacity and random command traffic.
import oiss_pkg::*;

class set_tracker;
	logic [VALUE_W-1:0] entries [CAPACITY_DEF];
	int unsigned        count;
	bit                 allow_dup;
	res_t               pending_results [$];
	int unsigned        errors;

	function int unsigned find_first(logic [VALUE_W-1:0] v);
		for (int unsigned i = 0; i < count; i++) begin
			if (entries[i] == v) return i;
		end
		return count;
	endfunction

	function void accept_command(req_t r);
		res_t        exp_res;
		int unsigned at;
		exp_res = '0;
		case (r.cmd)
			CMD_ADD: begin
				if (!allow_dup && find_first(r.value) < count) begin
					exp_res.success = 1'b0;
				end else if (count >= CAPACITY_DEF) begin
					exp_res.overflow = 1'b1;
				end else begin
					entries[count] = r.value;
					count++;
					exp_res.success = 1'b1;
				end
			end
			CMD_PEEK: begin
				exp_res.success = (find_first(r.value) < count);
			end
			CMD_POP: begin
				if (count > 0) begin
					count--;
					exp_res.popped_value = entries[count];
					exp_res.success = 1'b1;
				end
			end
			CMD_REMOVE: begin
				at = find_first(r.value);
				if (at < count) begin
					for (int unsigned i = at; i + 1 < count; i++) begin
						entries[i] = entries[i + 1];
					end
					count--;
					exp_res.success = 1'b1;
				end
			end
		endcase
		exp_res.entry_count = ENTRY_COUNT_W'(count);
		pending_results.push_back(exp_res);
	endfunction

	function void check_result(res_t got);
		res_t want;
		if (pending_results.size() == 0) begin
			$error("result with no transaction outstanding");
			errors++;
			return;
		end
		want = pending_results.pop_front();
		if (got.success !== want.success) begin
			$error("success: expected %0d, actual %0d", want.success, got.success);
			errors++;
		end
		if (got.popped_value !== want.popped_value) begin
			$error("popped_value: expected %0d, actual %0d", want.popped_value,
				got.popped_value);
			errors++;
		end
		if (got.overflow !== want.overflow) begin
			$error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
			errors++;
		end
		if (got.entry_count !== want.entry_count) begin
			$error("entry_count: expected %0d, actual %0d", want.entry_count,
				got.entry_count);
			errors++;
		end
	endfunction
endclass

module tb_ordered_int_set_stack;
	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        done;
	logic        cfg_we;
	logic        cfg_wdata;
	req_t        request;
	res_t        result;
	int unsigned idle_pct;
	set_tracker  tracker = new();

	ordered_int_set_stack DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.request   (request),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		if (done === 1'b1) tracker.check_result(result);
	end

	task automatic issue(cmd_t c, logic [VALUE_W-1:0] v);
		req_t r;
		r.cmd   = c;
		r.value = v;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy !== 1'b0);
		tracker.accept_command(r);
	endtask

	// drop start and wait out every outstanding transaction
	task automatic settle();
		start <= 1'b0;
		while (tracker.pending_results.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_dup(bit d);
		cfg_we    <= 1'b1;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.allow_dup = d;
	endtask

	function automatic cmd_t pick_cmd(int unsigned w_add, int unsigned w_peek,
		int unsigned w_pop);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < w_add) return CMD_ADD;
		if (roll < w_add + w_peek) return CMD_PEEK;
		if (roll < w_add + w_peek + w_pop) return CMD_POP;
		return CMD_REMOVE;
	endfunction

	task automatic random_run(int unsigned n, int unsigned w_add, int unsigned w_peek,
		int unsigned w_pop);
		logic [VALUE_W-1:0] v;
		for (int unsigned i = 0; i < n; i++) begin
			v = $urandom_range(1) ? VALUE_W'($urandom_range(15)) : VALUE_W'($urandom_range(255));
			issue(pick_cmd(w_add, w_peek, w_pop), v);
		end
	endtask

	initial begin
		#3_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		request   <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= 1'b0;
		idle_pct  = 27;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(CMD_POP, 8'hFF);
		issue(CMD_PEEK, 8'h00);
		issue(CMD_REMOVE, 8'h00);
		issue(CMD_ADD, 8'h00);
		issue(CMD_ADD, 8'hFF);
		issue(CMD_ADD, 8'h00);
		issue(CMD_PEEK, 8'h00);
		issue(CMD_PEEK, 8'hFF);
		issue(CMD_PEEK, 8'h01);
		issue(CMD_ADD, 8'hAA);
		issue(CMD_ADD, 8'h55);
		issue(CMD_REMOVE, 8'h00);
		issue(CMD_PEEK, 8'h00);
		issue(CMD_POP, 8'h00);
		issue(CMD_REMOVE, 8'hAA);
		issue(CMD_POP, 8'h5A);
		issue(CMD_POP, 8'hA5);
		settle();
		set_dup(1'b1);
		issue(CMD_ADD, 8'h07);
		issue(CMD_ADD, 8'h07);
		issue(CMD_ADD, 8'h09);
		issue(CMD_REMOVE, 8'h07);
		issue(CMD_PEEK, 8'h07);
		issue(CMD_POP, 8'h00);
		issue(CMD_POP, 8'h00);
		issue(CMD_POP, 8'h00);
		settle();
		set_dup(1'b0);

		random_run(120, 40, 20, 20);

		// fill to capacity with duplicates allowed, then hit the full store
		settle();
		set_dup(1'b1);
		idle_pct = 76;
		while (tracker.count < CAPACITY_DEF) begin
			issue(($urandom_range(9) == 0) ? CMD_PEEK : CMD_ADD, VALUE_W'($urandom_range(199)));
		end
		issue(CMD_ADD, 8'd250);
		issue(CMD_ADD, 8'd3);
		settle();
		set_dup(1'b0);
		issue(CMD_ADD, tracker.entries[0]);
		issue(CMD_ADD, 8'd250);
		issue(CMD_PEEK, 8'd250);
		issue(CMD_POP, 8'd0);
		issue(CMD_ADD, 8'd251);
		issue(CMD_ADD, 8'd252);
		issue(CMD_REMOVE, tracker.entries[CAPACITY_DEF / 2]);

		settle();
		set_dup(1'b1);
		idle_pct = 0;
		random_run(150, 20, 15, 40);

		settle();
		if (tracker.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

>>> sim.f
src/oiss_pkg.sv
src/oiss_cell.sv
src/oiss_ctrl.sv
src/ordered_int_set_stack.sv
tb/tb_ordered_int_set_stack.sv
